// File: rtl/core/ccim_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccim_pkg
// Shared types, constants and byte helpers of the chunked case-insensitive
// matcher.
// ----------------------------------------------------------------------------

package ccim_pkg;

   localparam int unsigned MaxNeedle  = 16;
   localparam int unsigned HistDepth  = MaxNeedle - 1;
   localparam int unsigned FillWidth  = $clog2(HistDepth + 1);
   localparam int unsigned LenWidth   = 5;
   localparam int unsigned ChunkWidth = 25;
   localparam int unsigned PosWidth   = 24;
   localparam int unsigned AddrWidth  = 5;
   localparam int unsigned DataWidth  = 64;

   localparam logic [ChunkWidth-1:0] DefaultChunk = 25'd262144;
   localparam logic [ChunkWidth-1:0] LargestChunk = 25'd16777216;

   typedef logic [7:0] char_type;

   localparam char_type CharTab   = 8'h09;
   localparam char_type CharLf    = 8'h0a;
   localparam char_type CharCr    = 8'h0d;
   localparam char_type CharSpace = 8'h20;
   localparam char_type CharDel   = 8'h7f;
   localparam char_type CharHigh  = 8'h80;
   localparam char_type CharUpA   = 8'h41;
   localparam char_type CharUpZ   = 8'h5a;
   localparam char_type CaseShift = 8'h20;

   typedef enum logic [1:0] {
      RegNeedleLow  = 2'd0,
      RegNeedleHigh = 2'd1,
      RegNeedleLen  = 2'd2,
      RegChunkBytes = 2'd3
   } reg_index_type;

   function automatic char_type fold_char(input char_type c);
      if (c inside {[CharUpA:CharUpZ]}) begin
         return c + CaseShift;
      end
      return c;
   endfunction

   function automatic char_type clean_char(input char_type c);
      if (c inside {CharTab, CharLf, CharCr, [CharSpace:CharDel - 8'd1],
                    [CharHigh:8'hff]}) begin
         return c;
      end
      return CharSpace;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/chunked_case_insensitive_matcher_unit.sv
// Only file_last requests give a response, via the input and response registers.
// Throughput: one byte per cycle; the history shift register and the 16 parallel
// byte compares sit between the input register and the response register.
// The input register keeps taking requests while a response waits on rsp_stall
// unless it holds a file_last byte itself.
// Reset (synchronous): configuration to defaults, window, position and hit cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// chunked_case_insensitive_matcher_unit
// Streams file bytes, cleans and case-folds them, and searches each chunk for
// the configured needle; reports a sticky hit flag with the last byte.
// ----------------------------------------------------------------------------

module chunked_case_insensitive_matcher_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [7:0]                      req_data_byte,
   input  wire logic                            req_file_last,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_file_hit,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [ccim_pkg::AddrWidth-1:0]  paddr,
   input  wire logic [ccim_pkg::DataWidth-1:0]  pwdata,
   output logic      [ccim_pkg::DataWidth-1:0]  prdata,
   output logic                                 pready
);

   // configuration
   logic [63:0]                        needle_low_ff, needle_low_in;
   logic [63:0]                        needle_high_ff, needle_high_in;
   logic [ccim_pkg::LenWidth-1:0]      needle_len_ff, needle_len_in;
   logic [ccim_pkg::ChunkWidth-1:0]    chunk_bytes_ff, chunk_bytes_in;
   ccim_pkg::reg_index_type            reg_sel;
   logic                               cfg_write;

   // input register
   logic                               s1_valid_ff, s1_valid_in;
   ccim_pkg::char_type                 s1_data_ff, s1_data_in;
   logic                               s1_last_ff, s1_last_in;

   // search state
   ccim_pkg::char_type                 hist_ff [ccim_pkg::HistDepth];
   ccim_pkg::char_type                 hist_in [ccim_pkg::HistDepth];
   logic [ccim_pkg::FillWidth-1:0]     fill_ff, fill_in;
   logic [ccim_pkg::PosWidth-1:0]      pos_ff, pos_in;
   logic                               hit_seen_ff, hit_seen_in;

   // response register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_hit_ff, rsp_hit_in;

   logic                               req_accept;
   logic                               s1_blocked;
   logic                               s1_advance;
   ccim_pkg::char_type                 cur;
   ccim_pkg::char_type                 needle_fold [ccim_pkg::MaxNeedle];
   ccim_pkg::char_type                 win         [ccim_pkg::MaxNeedle];
   logic [ccim_pkg::MaxNeedle-1:0]     pos_ok;
   logic [ccim_pkg::LenWidth-1:0]      tgt_idx     [ccim_pkg::MaxNeedle];
   logic                               len_ok;
   logic                               match;
   logic                               hit_now;
   logic [ccim_pkg::ChunkWidth-1:0]    chunk_eff;
   logic [ccim_pkg::ChunkWidth-1:0]    pos_next;
   logic                               chunk_end;

   assign reg_sel   = ccim_pkg::reg_index_type'(paddr[4:3]);
   assign cfg_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      needle_low_in  = needle_low_ff;
      needle_high_in = needle_high_ff;
      needle_len_in  = needle_len_ff;
      chunk_bytes_in = chunk_bytes_ff;
      if (cfg_write) begin
         case (reg_sel)
            ccim_pkg::RegNeedleLow:  needle_low_in  = pwdata;
            ccim_pkg::RegNeedleHigh: needle_high_in = pwdata;
            ccim_pkg::RegNeedleLen:  needle_len_in  = pwdata[ccim_pkg::LenWidth-1:0];
            ccim_pkg::RegChunkBytes: chunk_bytes_in = pwdata[ccim_pkg::ChunkWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         ccim_pkg::RegNeedleLow:  prdata = needle_low_ff;
         ccim_pkg::RegNeedleHigh: prdata = needle_high_ff;
         ccim_pkg::RegNeedleLen:
            prdata = {{(ccim_pkg::DataWidth - ccim_pkg::LenWidth){1'b0}}, needle_len_ff};
         ccim_pkg::RegChunkBytes:
            prdata = {{(ccim_pkg::DataWidth - ccim_pkg::ChunkWidth){1'b0}}, chunk_bytes_ff};
         default: prdata = '0;
      endcase
   end

   // handshake
   assign s1_blocked = s1_last_ff && rsp_valid_ff && rsp_stall;
   assign s1_advance = s1_valid_ff && !s1_blocked;
   assign req_stall  = s1_valid_ff && s1_blocked;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      s1_last_in  = s1_last_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data_byte;
         s1_last_in  = req_file_last;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // compare
   assign cur = ccim_pkg::fold_char(ccim_pkg::clean_char(s1_data_ff));

   always_comb begin
      for (int j = 0; j < ccim_pkg::MaxNeedle; j++) begin
         if (j < 8) begin
            needle_fold[j] = ccim_pkg::fold_char(needle_low_ff[8*j +: 8]);
         end else begin
            needle_fold[j] = ccim_pkg::fold_char(needle_high_ff[8*(j-8) +: 8]);
         end
      end
   end

   always_comb begin
      win[0] = cur;
      for (int m = 1; m < ccim_pkg::MaxNeedle; m++) begin
         win[m] = hist_ff[m-1];
      end
   end

   always_comb begin
      for (int m = 0; m < ccim_pkg::MaxNeedle; m++) begin
         tgt_idx[m] = needle_len_ff - ccim_pkg::LenWidth'(m + 1);
         pos_ok[m]  = (ccim_pkg::LenWidth'(m) >= needle_len_ff) ||
                      (win[m] == needle_fold[tgt_idx[m][3:0]]);
      end
   end

   assign len_ok = (needle_len_ff != '0) &&
                   (needle_len_ff <= ccim_pkg::LenWidth'(ccim_pkg::MaxNeedle)) &&
                   ({1'b0, fill_ff} + 5'd1 >= needle_len_ff);
   assign match   = len_ok && (&pos_ok);
   assign hit_now = hit_seen_ff || match;

   // chunk bookkeeping
   always_comb begin
      if (chunk_bytes_ff == '0) begin
         chunk_eff = ccim_pkg::DefaultChunk;
      end else if (chunk_bytes_ff > ccim_pkg::LargestChunk) begin
         chunk_eff = ccim_pkg::LargestChunk;
      end else begin
         chunk_eff = chunk_bytes_ff;
      end
   end

   assign pos_next  = {1'b0, pos_ff} + 25'd1;
   assign chunk_end = pos_next >= chunk_eff;

   always_comb begin
      hist_in      = hist_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      hit_seen_in  = hit_seen_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_advance) begin
         hist_in[0] = cur;
         for (int m = 1; m < ccim_pkg::HistDepth; m++) begin
            hist_in[m] = hist_ff[m-1];
         end
         if (fill_ff != ccim_pkg::FillWidth'(ccim_pkg::HistDepth)) begin
            fill_in = fill_ff + 1'b1;
         end
         pos_in      = pos_next[ccim_pkg::PosWidth-1:0];
         hit_seen_in = hit_now;
         if (chunk_end || s1_last_ff) begin
            fill_in = '0;
            pos_in  = '0;
         end
         if (s1_last_ff) begin
            hit_seen_in  = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_hit_in   = hit_now;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_file_hit = rsp_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_low_ff  <= '0;
         needle_high_ff <= '0;
         needle_len_ff  <= '0;
         chunk_bytes_ff <= ccim_pkg::DefaultChunk;
         s1_valid_ff    <= 1'b0;
         fill_ff        <= '0;
         pos_ff         <= '0;
         hit_seen_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         needle_low_ff  <= needle_low_in;
         needle_high_ff <= needle_high_in;
         needle_len_ff  <= needle_len_in;
         chunk_bytes_ff <= chunk_bytes_in;
         s1_valid_ff    <= s1_valid_in;
         fill_ff        <= fill_in;
         pos_ff         <= pos_in;
         hit_seen_ff    <= hit_seen_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      s1_last_ff <= s1_last_in;
      hist_ff    <= hist_in;
      rsp_hit_ff <= rsp_hit_in;
   end

`ifndef SYNTHESIS
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("response raised without a file_last request");

   a_file_end_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_last_ff) |=> (!hit_seen_ff && fill_ff == '0 && pos_ff == '0))
      else $error("file end did not clear search state");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && s1_last_ff))
      else $error("request stalled without a held response");
`endif

endmodule

`default_nettype wire

// File: tb/chunked_case_insensitive_matcher_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chunked_case_insensitive_matcher_unit_tb
// Streams files of bytes through the matcher under several needle and chunk
// settings, with random gaps and back-pressure, and checks every file_hit
// response against a cycle-free model of the cleaning, case folding and
// chunked needle search. Register read-back is checked after each write.
// ----------------------------------------------------------------------------

module chunked_case_insensitive_matcher_unit_tb;

   localparam int CycleLimit = 600000;

   class file_hit_scoreboard;
      bit [63:0] needle_lo;
      bit [63:0] needle_hi;
      bit [4:0]  needle_len;
      bit [24:0] chunk_bytes;
      bit [7:0]  history[ccim_pkg::HistDepth];
      bit [4:0]  fill;
      bit [24:0] position;
      bit        hit;
      bit        expected_hits[$];
      int        errors;
      int        files;
      int        hit_files;

      function new();
         needle_lo   = '0;
         needle_hi   = '0;
         needle_len  = '0;
         chunk_bytes = ccim_pkg::DefaultChunk;
         hit         = 1'b0;
         clear_window();
      endfunction

      function void clear_window();
         foreach (history[i]) history[i] = '0;
         fill     = '0;
         position = '0;
      endfunction

      function bit [7:0] fold(bit [7:0] c);
         if (c >= ccim_pkg::CharUpA && c <= ccim_pkg::CharUpZ) return c + ccim_pkg::CaseShift;
         return c;
      endfunction

      function bit [7:0] clean(bit [7:0] c);
         if (c == ccim_pkg::CharTab || c == ccim_pkg::CharLf || c == ccim_pkg::CharCr ||
             (c >= ccim_pkg::CharSpace && c < ccim_pkg::CharDel) ||
             c >= ccim_pkg::CharHigh) return c;
         return ccim_pkg::CharSpace;
      endfunction

      function bit [7:0] needle_char(int i);
         bit [63:0] word;
         word = (i < 8) ? needle_lo : needle_hi;
         return word[(i % 8) * 8 +: 8];
      endfunction

      function void set_reg(ccim_pkg::reg_index_type idx, bit [63:0] value);
         case (idx)
            ccim_pkg::RegNeedleLow:  needle_lo   = value;
            ccim_pkg::RegNeedleHigh: needle_hi   = value;
            ccim_pkg::RegNeedleLen:  needle_len  = value[4:0];
            ccim_pkg::RegChunkBytes: chunk_bytes = value[24:0];
            default: ;
         endcase
      endfunction

      function bit [63:0] reg_value(ccim_pkg::reg_index_type idx);
         case (idx)
            ccim_pkg::RegNeedleLow:  return needle_lo;
            ccim_pkg::RegNeedleHigh: return needle_hi;
            ccim_pkg::RegNeedleLen:  return 64'(needle_len);
            default:                 return 64'(chunk_bytes);
         endcase
      endfunction

      function void flag(string what, bit [63:0] exp_value, bit [63:0] got_value);
         errors++;
         if (errors <= 10)
            $display("mismatch %s: expected %0h, got %0h", what, exp_value, got_value);
      endfunction

      function void note_byte(bit [7:0] raw, bit last);
         bit [7:0]  cur;
         bit [24:0] span;
         bit        ok;
         int        k;
         cur  = fold(clean(raw));
         span = chunk_bytes;
         if (span == 0) span = ccim_pkg::DefaultChunk;
         if (span > ccim_pkg::LargestChunk) span = ccim_pkg::LargestChunk;
         if (needle_len >= 1 && needle_len <= ccim_pkg::MaxNeedle && fill + 1 >= needle_len)
         begin
            ok = (fold(needle_char(needle_len - 1)) == cur);
            for (k = 1; k < needle_len; k++) begin
               if (fold(needle_char(needle_len - 1 - k)) != history[k - 1]) ok = 1'b0;
            end
            if (ok) hit = 1'b1;
         end
         for (k = ccim_pkg::HistDepth - 1; k > 0; k--) history[k] = history[k - 1];
         history[0] = cur;
         if (fill < ccim_pkg::HistDepth) fill++;
         position++;
         if (position >= span) clear_window();
         if (last) begin
            expected_hits = {expected_hits, hit};
            files++;
            if (hit) hit_files++;
            clear_window();
            hit = 1'b0;
         end
      endfunction

      function void check_hit(bit got);
         if (expected_hits.size() == 0) begin
            errors++;
            if (errors <= 10) $display("mismatch: response %0b with no request pending", got);
            return;
         end
         if (expected_hits[0] != got) flag("file_hit", 64'(expected_hits[0]), 64'(got));
         void'(expected_hits.pop_front());
      endfunction
   endclass

   bit         clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       req_file_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_file_hit;
   logic       psel;
   logic       penable;
   logic       pwrite;
   logic [ccim_pkg::AddrWidth-1:0] paddr;
   logic [ccim_pkg::DataWidth-1:0] pwdata;
   logic [ccim_pkg::DataWidth-1:0] prdata;
   logic       pready;

   file_hit_scoreboard tracker = new();
   bit   quiet = 1'b0;
   int   cycle_count = 0;
   int   bytes_sent = 0;
   int   settings = 0;
   bit [7:0] needle_bytes[ccim_pkg::MaxNeedle];
   int   needle_count = 0;

   chunked_case_insensitive_matcher_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_file_last(req_file_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_file_hit(rsp_file_hit),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_hit(rsp_file_hit);
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset && !quiet && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic csr_access(input bit wr, input ccim_pkg::reg_index_type idx,
                             input bit [63:0] wdata, output bit [63:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 3'b000};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_reg(input ccim_pkg::reg_index_type idx);
      bit [63:0] rdata;
      csr_access(1'b0, idx, '0, rdata);
      if (rdata != tracker.reg_value(idx)) tracker.flag(idx.name(), tracker.reg_value(idx), rdata);
   endtask

   task automatic apply_reg(input ccim_pkg::reg_index_type idx, input bit [63:0] value);
      bit [63:0] rdata;
      csr_access(1'b1, idx, value, rdata);
      tracker.set_reg(idx, value);
      check_reg(idx);
   endtask

   task automatic set_needle(input int len);
      bit [63:0] lo;
      bit [63:0] hi;
      for (int i = 0; i < 8; i++) begin
         lo[8 * i +: 8] = needle_bytes[i];
         hi[8 * i +: 8] = needle_bytes[i + 8];
      end
      apply_reg(ccim_pkg::RegNeedleLow, lo);
      apply_reg(ccim_pkg::RegNeedleHigh, hi);
      apply_reg(ccim_pkg::RegNeedleLen, 64'(len));
      needle_count = len;
      settings++;
   endtask

   task automatic send_request(input bit [7:0] data, input bit last);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_file_last <= last;
      do @(posedge clock); while (!(req_valid && !req_stall));
      tracker.note_byte(data, last);
      bytes_sent++;
      @(negedge clock);
   endtask

   // drain all responses, then give the pipeline time to empty
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.expected_hits.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   function automatic bit [7:0] vary(bit [7:0] b);
      bit [7:0] c;
      if (b >= 8'h61 && b <= 8'h7a) b = b - ccim_pkg::CaseShift;
      if (b >= ccim_pkg::CharUpA && b <= ccim_pkg::CharUpZ)
         return $urandom_range(0, 1) ? b : b + ccim_pkg::CaseShift;
      if (b == ccim_pkg::CharSpace && $urandom_range(0, 1)) begin
         c = 8'($urandom_range(0, 31));
         if (c == ccim_pkg::CharTab || c == ccim_pkg::CharLf || c == ccim_pkg::CharCr)
            c = ccim_pkg::CharDel;
         return c;
      end
      return b;
   endfunction

   function automatic bit [7:0] filler();
      int top;
      top = (needle_count >= 1 && needle_count <= ccim_pkg::MaxNeedle) ?
            needle_count - 1 : int'(ccim_pkg::MaxNeedle) - 1;
      case ($urandom_range(0, 3))
         0, 1:    return vary(needle_bytes[$urandom_range(0, top)]);
         2:       return 8'($urandom_range(32, 126));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic run_files(input int count);
      bit [7:0] body[$];
      int flen;
      int at;
      int goal;
      goal = bytes_sent + count;
      while (bytes_sent < goal) begin
         body.delete();
         flen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 24);
         if ($urandom_range(0, 9) < 7 && needle_count >= 1 &&
             needle_count <= ccim_pkg::MaxNeedle) begin
            at = $urandom_range(0, flen);
            for (int i = 0; i < flen; i++) begin
               if (i == at) begin
                  for (int j = 0; j < needle_count; j++) body = {body, vary(needle_bytes[j])};
               end
               body = {body, filler()};
            end
            if (at == flen)
               for (int j = 0; j < needle_count; j++) body = {body, vary(needle_bytes[j])};
            if ($urandom_range(0, 4) == 0)
               body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(0, 255));
         end else begin
            for (int i = 0; i < flen; i++)
               body = {body, ($urandom_range(0, 1) ? filler() : 8'($urandom_range(0, 255)))};
         end
         foreach (body[i]) send_request(body[i], i == body.size() - 1);
      end
   endtask

   initial begin
      int len;
      bit [24:0] chunk;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = '0;
      req_file_last = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      check_reg(ccim_pkg::RegNeedleLow);
      check_reg(ccim_pkg::RegNeedleHigh);
      check_reg(ccim_pkg::RegNeedleLen);
      check_reg(ccim_pkg::RegChunkBytes);

      // empty needle never matches
      send_request(8'h61, 1'b1);
      settle();

      // mixed case, control byte cleaned to a space, byte extremes
      foreach (needle_bytes[i]) needle_bytes[i] = '0;
      needle_bytes[0] = 8'h61;
      needle_bytes[1] = 8'h42;
      needle_bytes[2] = ccim_pkg::CharSpace;
      needle_bytes[3] = 8'h63;
      set_needle(4);
      send_request(8'h41, 1'b0);
      send_request(8'h62, 1'b0);
      send_request(8'h01, 1'b0);
      send_request(8'h43, 1'b1);
      send_request(8'h00, 1'b0);
      send_request(8'hff, 1'b1);
      settle();

      // full-length needle of 0xff, oversized chunk
      foreach (needle_bytes[i]) needle_bytes[i] = 8'hff;
      set_needle(ccim_pkg::MaxNeedle);
      apply_reg(ccim_pkg::RegChunkBytes, 64'h1ff_ffff);
      for (int i = 0; i < ccim_pkg::MaxNeedle; i++)
         send_request(8'hff, i == ccim_pkg::MaxNeedle - 1);
      settle();

      // needle straddling a chunk boundary is missed
      foreach (needle_bytes[i]) needle_bytes[i] = '0;
      needle_bytes[0] = 8'h61;
      needle_bytes[1] = 8'h62;
      set_needle(2);
      apply_reg(ccim_pkg::RegChunkBytes, 64'd2);
      send_request(8'h78, 1'b0);
      send_request(8'h61, 1'b0);
      send_request(8'h62, 1'b1);

      for (int ph = 0; ph < 8; ph++) begin
         settle();
         quiet = (ph == 7);
         case (ph)
            0: begin len = $urandom_range(1, 16); chunk = 25'd0;                   end
            1: begin len = 1;                     chunk = 25'd1;                   end
            2: begin len = 3;                     chunk = 25'($urandom_range(3, 12)); end
            3: begin len = 16;                    chunk = ccim_pkg::LargestChunk;  end
            4: begin len = 31;                    chunk = 25'h1ff_ffff;            end
            5: begin len = 0;                     chunk = 25'($urandom_range(2, 40)); end
            6: begin len = $urandom_range(1, 16); chunk = ccim_pkg::DefaultChunk;  end
            default: begin
               len   = $urandom_range(2, 8);
               chunk = 25'($urandom_range(4, 20));
            end
         endcase
         foreach (needle_bytes[i]) begin
            case ($urandom_range(0, 19))
               0, 1:    needle_bytes[i] = ccim_pkg::CharSpace;
               2:       needle_bytes[i] = 8'($urandom_range(8'h30, 8'h39));
               3, 4:    needle_bytes[i] = 8'($urandom_range(8'h80, 8'hff));
               5:       needle_bytes[i] = 8'($urandom_range(0, 31));
               default: needle_bytes[i] = $urandom_range(0, 1) ?
                                          8'($urandom_range(8'h41, 8'h5a)) :
                                          8'($urandom_range(8'h61, 8'h7a));
            endcase
            if (ph == 5) needle_bytes[i] = '0;
         end
         set_needle(len);
         apply_reg(ccim_pkg::RegChunkBytes, 64'(chunk));
         if (ph == 2) begin
            run_files(120);
            settle();
            run_files(120);
         end else begin
            run_files(240);
         end
      end

      req_valid <= 1'b0;
      while (tracker.expected_hits.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("sent %0d bytes in %0d files, %0d of them hits", bytes_sent, tracker.files,
               tracker.hit_files);
      $display("%0d needle settings, chunk sizes from 1 to beyond the largest", settings);
      if (tracker.errors == 0 && tracker.expected_hits.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", tracker.errors);
         $display("FAIL");
      end
      $finish;
   end

endmodule
